[rtl/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the difference enumerator.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition holds on every clock edge outside reset
`define ASSERT_ALWAYS(label, cond, msg) \
    `ASSERT_CLK(label, (1'b1 |-> (cond)), msg)

`endif

[rtl/arde_pkg.sv]
// Shared types and constants for the rotate-and-AND difference enumerator.
// No dependencies.
`default_nettype none

package arde_pkg;

    // Word geometry
    localparam int MAX_WORD  = 32;
    localparam int MIN_WORD  = 9;
    localparam int WORD_W    = 32;
    localparam int CNT_W     = 6;
    localparam int RANK_W    = 5;
    localparam int ENUM_W    = 64;
    localparam int NM_W      = 7;

    // Reset word size and rotation amounts
    localparam logic [CNT_W-1:0] WORD_BITS_RST = CNT_W'(16);
    localparam logic [CNT_W-1:0] ROT_MASK_A    = CNT_W'(1);
    localparam logic [CNT_W-1:0] ROT_MASK_B    = CNT_W'(8);
    localparam logic [CNT_W-1:0] ROT_LEFT      = CNT_W'(2);

    // Request codes
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_NEXT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HOLD
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic take_load;
        logic take_next;
        logic scan_step;
    } ctrl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic scan_done;
    } dp_sts_t;

endpackage

`default_nettype wire

[rtl/arde_ctrl.sv]
// Controller state machine of the difference enumerator: handshakes and scan sequencing.
// Depends on arde_pkg.
`default_nettype none

module arde_ctrl
    import arde_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire logic      req_type,
    output logic           out_valid,
    input  wire logic      out_ready,
    input  wire dp_sts_t   sts,
    output ctrl_cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // Take a new item when idle or when the pending result leaves this cycle
    assign in_ready = (state_reg == ST_IDLE) || ((state_reg == ST_HOLD) && out_ready);
    assign accept   = in_valid && in_ready;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (req_type == REQ_NEXT) ? ST_HOLD : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (accept)
                begin
                    state_next = (req_type == REQ_NEXT) ? ST_HOLD : ST_SCAN;
                end
                else if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Drive commands and output valid
    always_comb
    begin
        cmd.take_load = accept && (req_type == REQ_LOAD);
        cmd.take_next = accept && (req_type == REQ_NEXT);
        cmd.scan_step = 1'b0;
        out_valid     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            ST_HOLD:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/arde_dpath.sv]
// Datapath of the difference enumerator: word-size register, bit scan with rank table,
// running counter and candidate XOR network. Depends on arde_pkg.
`default_nettype none

module arde_dpath
    import arde_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [CNT_W-1:0]   cfg_wdata,
    input  wire logic [WORD_W-1:0]  left_in,
    input  wire logic [WORD_W-1:0]  right_in,
    input  wire ctrl_cmd_t          cmd,
    output dp_sts_t                 sts,
    output logic [WORD_W-1:0]       cand_diff,
    output logic                    cand_valid,
    output logic                    cand_last,
    output logic [CNT_W-1:0]        active_bits_seen
);

    // Rotate left by s within the low w bits; bits at or above w read as zero
    function automatic logic [WORD_W-1:0] rotl_w(
        input logic [WORD_W-1:0] v,
        input logic [CNT_W-1:0]  s,
        input logic [CNT_W-1:0]  w
    );
        logic [WORD_W-1:0] r;
        logic [CNT_W-1:0]  src;
        logic [CNT_W-1:0]  q6;
        r   = '0;
        src = '0;
        for (int q = 0; q < WORD_W; q++)
        begin
            q6 = CNT_W'(q);
            if (q6 < w)
            begin
                if (q6 >= s)
                begin
                    src = q6 - s;
                end
                else
                begin
                    src = q6 + w - s;
                end
                r[q] = v[src[RANK_W-1:0]];
            end
        end
        return r;
    endfunction

    logic [CNT_W-1:0]  word_bits_reg;
    logic [CNT_W-1:0]  w_eff;
    logic [WORD_W-1:0] w_mask;

    logic [WORD_W-1:0] left_reg;
    logic [WORD_W-1:0] right_reg;
    logic [CNT_W-1:0]  wl_reg;
    logic [RANK_W-1:0] rank_reg [WORD_W];
    logic [RANK_W-1:0] scan_idx_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [ENUM_W-1:0] enum_reg;
    logic              exh_reg;

    logic [WORD_W-1:0] sel_a;
    logic [WORD_W-1:0] sel_b;
    logic [WORD_W-1:0] cand;
    logic [NM_W-1:0]   nm;
    logic [ENUM_W-1:0] low_mask;
    logic              is_last;
    logic              scan_bit;

    // Clamp the configured word size
    always_comb
    begin
        if (word_bits_reg < CNT_W'(MIN_WORD))
        begin
            w_eff = CNT_W'(MIN_WORD);
        end
        else if (word_bits_reg > CNT_W'(MAX_WORD))
        begin
            w_eff = CNT_W'(MAX_WORD);
        end
        else
        begin
            w_eff = word_bits_reg;
        end
        for (int q = 0; q < WORD_W; q++)
        begin
            w_mask[q] = (CNT_W'(q) < w_eff);
        end
    end

    // Scan one bit position per cycle
    assign scan_bit      = left_reg[scan_idx_reg];
    assign count_next    = count_reg + CNT_W'(scan_bit);
    assign sts.scan_done = ({1'b0, scan_idx_reg} == (wl_reg - CNT_W'(1)));

    // Gather counter bits at each active position through its rank
    always_comb
    begin
        for (int p = 0; p < WORD_W; p++)
        begin
            sel_a[p] = left_reg[p] & enum_reg[{rank_reg[p], 1'b0}];
            sel_b[p] = left_reg[p] & enum_reg[{rank_reg[p], 1'b1}];
        end
    end

    // Combine right, rotated left and the selected masks
    assign cand = right_reg
                ^ rotl_w(left_reg, ROT_LEFT, w_eff)
                ^ rotl_w(sel_a, ROT_MASK_A, wl_reg)
                ^ rotl_w(sel_b, ROT_MASK_B, wl_reg);

    // Detect the final counter value: all of the low 2k bits set
    assign nm = {1'b0, count_reg} << 1;
    always_comb
    begin
        for (int i = 0; i < ENUM_W; i++)
        begin
            low_mask[i] = (NM_W'(i) < nm);
        end
    end
    assign is_last = &(enum_reg | ~low_mask);

    // Hold configuration, count and enumeration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_bits_reg <= WORD_BITS_RST;
            count_reg     <= '0;
            enum_reg      <= '0;
            exh_reg       <= 1'b1;
        end
        else
        begin
            if (cfg_we)
            begin
                word_bits_reg <= cfg_wdata;
            end
            if (cmd.take_load)
            begin
                count_reg <= '0;
                enum_reg  <= '0;
                exh_reg   <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                count_reg <= count_next;
            end
            else if (cmd.take_next && !exh_reg)
            begin
                if (is_last)
                begin
                    exh_reg <= 1'b1;
                end
                else
                begin
                    enum_reg <= enum_reg + ENUM_W'(1);
                end
            end
        end
    end

    // Latch the loaded pair, advance the scan, record ranks
    always_ff @(posedge clk)
    begin
        if (cmd.take_load)
        begin
            left_reg     <= left_in & w_mask;
            right_reg    <= right_in & w_mask;
            wl_reg       <= w_eff;
            scan_idx_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            scan_idx_reg <= scan_idx_reg + RANK_W'(1);
            if (scan_bit)
            begin
                rank_reg[scan_idx_reg] <= count_reg[RANK_W-1:0];
            end
        end
    end

    // Load the result registers
    always_ff @(posedge clk)
    begin
        if (cmd.scan_step && sts.scan_done)
        begin
            cand_diff        <= '0;
            cand_valid       <= 1'b0;
            cand_last        <= 1'b0;
            active_bits_seen <= count_next;
        end
        else if (cmd.take_next)
        begin
            cand_diff        <= exh_reg ? '0 : cand;
            cand_valid       <= !exh_reg;
            cand_last        <= !exh_reg && is_last;
            active_bits_seen <= count_reg;
        end
    end

endmodule

`default_nettype wire

[rtl/and_rotation_difference_enumerator.sv]
// Rotate-and-AND difference enumerator, top level.
// Next request: result valid in the cycle after the transfer; one per cycle when output drains.
// Load request: result follows the rank scan, which covers one bit position per cycle.
// Reset (async, active low): word size 16, nothing loaded, next requests answer invalid.
// Depends on arde_pkg, arde_ctrl, arde_dpath and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module and_rotation_difference_enumerator
    import arde_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [CNT_W-1:0]   cfg_wdata,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               req_type,
    input  wire logic [WORD_W-1:0]  left_in,
    input  wire logic [WORD_W-1:0]  right_in,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [WORD_W-1:0]       cand_diff,
    output logic                    cand_valid,
    output logic                    cand_last,
    output logic [CNT_W-1:0]        active_bits_seen
);

    ctrl_cmd_t cmd;
    dp_sts_t   sts;

    // Sequence transfers and the scan
    arde_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Compute candidates and load results
    arde_dpath u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .left_in          (left_in),
        .right_in         (right_in),
        .cmd              (cmd),
        .sts              (sts),
        .cand_diff        (cand_diff),
        .cand_valid       (cand_valid),
        .cand_last        (cand_last),
        .active_bits_seen (active_bits_seen)
    );

    // A load transfer blocks input while the scan runs
    `ASSERT_CLK(a_load_blocks, (in_valid && in_ready && (req_type == REQ_LOAD)) |=> !in_ready, "input taken during scan")
    // A final candidate is always a valid one
    `ASSERT_CLK(a_last_valid, (out_valid && cand_last) |-> cand_valid, "last without valid")
    // No candidate means a zero word
    `ASSERT_CLK(a_zero_invalid, (out_valid && !cand_valid) |-> (cand_diff == '0), "nonzero invalid candidate")
    // The active count never exceeds the word size
    `ASSERT_CLK(a_count_range, out_valid |-> (active_bits_seen <= CNT_W'(MAX_WORD)), "active count out of range")

endmodule

`default_nettype wire
